[rtl/shipdr_pkg.sv]
// Shared types, constants and helpers for the SHiP/DRRIP replacement engine.
// Depends on nothing; used by every module of the block but shipdr_ram.
`default_nettype none

package shipdr_pkg;

  // Default sizing of the engine.
  localparam int SETS_DEF        = 2048;
  localparam int WAYS_DEF        = 16;
  localparam int LEADER_SETS_DEF = 64;
  localparam int SIG_BITS_DEF    = 6;

  // Fixed field widths at the ports.
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int PC_W     = 18;
  localparam int WAY_OUT_W = 4;

  // RRPV codes.
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;

  // Signature counter codes.
  localparam logic [1:0] CTR_RESET  = 2'd1;
  localparam logic [1:0] CTR_STRONG = 2'd2;
  localparam logic [1:0] CTR_MAX    = 2'd3;

  // Policy selector and bimodal throttle.
  localparam int          PSEL_W   = 10;
  localparam logic [9:0]  PSEL_MAX = 10'd1023;
  localparam logic [9:0]  PSEL_MID = 10'd512;
  localparam int          BIM_W    = 5;

  // Controller -> datapath commands.
  typedef struct packed {
    logic clr;        // clearing pass step
    logic accept;     // item taken, start row reads
    logic hit_wr;     // finish a hit
    logic miss_eval;  // age set, pick victim, read victim counter
    logic miss_wr;    // finish a miss
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic clr_last;
    logic hit;
    logic out_free;
  } status_t;

  // Remainder of value by m, valid when value < 16*m.
  function automatic logic [31:0] reduce_mod(input logic [31:0] value, input logic [31:0] m);
    logic [31:0] v;
    v = value;
    for (int k = 3; k >= 0; k--) begin
      if (v >= (m << k)) v = v - (m << k);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/shipdr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module shipdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/shipdr_ctrl.sv]
// Sequencer for the replacement engine: clear pass, accept, evaluate, victim fill.
// Depends on shipdr_pkg (cmd_t, status_t).
`default_nettype none

module shipdr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire shipdr_pkg::status_t sts,
  output shipdr_pkg::cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_VICT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;

  assign in_tready = in_tready_r;

  always_comb begin
    cmd           = '0;
    cmd.clr       = (state_r == ST_CLEAR);
    cmd.accept    = (state_r == ST_IDLE) && in_tvalid && in_tready_r;
    cmd.hit_wr    = (state_r == ST_EVAL) && sts.hit && sts.out_free;
    cmd.miss_eval = (state_r == ST_EVAL) && !sts.hit;
    cmd.miss_wr   = (state_r == ST_VICT) && sts.out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready_nxt = in_tready_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt     = ST_IDLE;
          in_tready_nxt = 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt     = ST_EVAL;
          in_tready_nxt = 1'b0;
        end
      end
      ST_EVAL: begin
        if (!sts.hit) begin
          state_nxt = ST_VICT;
        end else if (sts.out_free) begin
          state_nxt     = ST_IDLE;
          in_tready_nxt = 1'b1;
        end
      end
      ST_VICT: begin
        if (sts.out_free) begin
          state_nxt     = ST_IDLE;
          in_tready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt     = ST_CLEAR;
        in_tready_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/shipdr_dpath.sv]
// Datapath: metadata RAMs, signature hash, aging/victim logic, PSEL, output register.
// Depends on shipdr_pkg and shipdr_ram.
`default_nettype none

module shipdr_dpath #(
  parameter int SETS        = shipdr_pkg::SETS_DEF,
  parameter int WAYS        = shipdr_pkg::WAYS_DEF,
  parameter int LEADER_SETS = shipdr_pkg::LEADER_SETS_DEF,
  parameter int SIG_BITS    = shipdr_pkg::SIG_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire shipdr_pkg::cmd_t                   cmd,
  output shipdr_pkg::status_t                     sts,
  input  wire logic [shipdr_pkg::SET_IN_W-1:0]    set_index_i,
  input  wire logic [shipdr_pkg::WAY_IN_W-1:0]    hit_way_i,
  input  wire logic [shipdr_pkg::PC_W-1:0]        pc_i,
  input  wire logic                               hit_i,
  input  wire logic                               out_tready,
  output logic                                    out_tvalid,
  output logic      [shipdr_pkg::WAY_OUT_W-1:0]   chosen_way_o,
  output logic                                    is_victim_o
);

  localparam int SET_W     = $clog2(SETS);
  localparam int WAY_W     = $clog2(WAYS);
  localparam int SIG_CNT   = 1 << SIG_BITS;
  localparam int CLR_LEN   = (SETS > SIG_CNT) ? SETS : SIG_CNT;
  localparam int CLR_W     = $clog2(CLR_LEN);
  localparam int RR_ROW_W  = WAYS * 2;
  localparam int SIG_ROW_W = WAYS * SIG_BITS;

  // ---------------- input reduction and hash ----------------
  logic [31:0]          set_mod, way_mod;
  logic [SET_W-1:0]     set_red;
  logic [WAY_W-1:0]     way_red;
  logic [shipdr_pkg::PC_W-1:0] sig_full;
  logic [SIG_BITS-1:0]  sig_in;

  assign set_mod  = shipdr_pkg::reduce_mod(32'(set_index_i), 32'(SETS));
  assign way_mod  = shipdr_pkg::reduce_mod(32'(hit_way_i), 32'(WAYS));
  assign set_red  = set_mod[SET_W-1:0];
  assign way_red  = way_mod[WAY_W-1:0];
  assign sig_full = pc_i ^ (pc_i >> SIG_BITS) ^ (pc_i >> (2 * SIG_BITS));
  assign sig_in   = sig_full[SIG_BITS-1:0];

  logic [SET_W-1:0]    set_r;
  logic [WAY_W-1:0]    way_r;
  logic [SIG_BITS-1:0] sig_r;
  logic                hit_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_r <= set_red;
      way_r <= way_red;
      sig_r <= sig_in;
      hit_r <= hit_i;
    end
  end

  // ---------------- clearing pass counter ----------------
  logic [CLR_W-1:0] clr_cnt_r;
  logic             clr_set_ok, clr_sig_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr) clr_cnt_r <= clr_cnt_r + CLR_W'(1);
  end

  assign clr_set_ok = (32'(clr_cnt_r) < SETS);
  assign clr_sig_ok = (32'(clr_cnt_r) < SIG_CNT);

  // ---------------- memories ----------------
  logic [RR_ROW_W-1:0]  rr_row_q, rr_wdata, rr_hit_row, rr_miss_row;
  logic [SIG_ROW_W-1:0] sg_row_q, sg_wdata, sg_miss_row;
  logic [1:0]           ctr_q, ctr_wdata;
  logic [SIG_BITS-1:0]  ctr_waddr, ctr_raddr;
  logic [SET_W-1:0]     row_waddr;
  logic                 rr_we, sg_we, ctr_we, ctr_re;
  logic [SIG_BITS-1:0]  vsig_now;

  assign row_waddr = cmd.clr ? clr_cnt_r[SET_W-1:0] : set_r;
  assign rr_we     = (cmd.clr && clr_set_ok) || cmd.hit_wr || cmd.miss_wr;
  assign rr_wdata  = cmd.clr ? {WAYS{shipdr_pkg::RRPV_DISTANT}}
                   : (cmd.hit_wr ? rr_hit_row : rr_miss_row);
  assign sg_we     = (cmd.clr && clr_set_ok) || cmd.miss_wr;
  assign sg_wdata  = cmd.clr ? '0 : sg_miss_row;

  shipdr_ram #(.WIDTH(RR_ROW_W), .DEPTH(SETS)) u_rr_ram (
    .clk   (clk),
    .we    (rr_we),
    .waddr (row_waddr),
    .wdata (rr_wdata),
    .re    (cmd.accept),
    .raddr (set_red),
    .rdata (rr_row_q)
  );

  shipdr_ram #(.WIDTH(SIG_ROW_W), .DEPTH(SETS)) u_sig_ram (
    .clk   (clk),
    .we    (sg_we),
    .waddr (row_waddr),
    .wdata (sg_wdata),
    .re    (cmd.accept),
    .raddr (set_red),
    .rdata (sg_row_q)
  );

  logic [SIG_BITS-1:0] vsig_r;
  logic [1:0]          ctr_inc, ctr_dec;

  assign ctr_we    = (cmd.clr && clr_sig_ok) || cmd.hit_wr || cmd.miss_wr;
  assign ctr_waddr = cmd.clr ? clr_cnt_r[SIG_BITS-1:0] : (cmd.hit_wr ? sig_r : vsig_r);
  assign ctr_wdata = cmd.clr ? shipdr_pkg::CTR_RESET : (cmd.hit_wr ? ctr_inc : ctr_dec);
  assign ctr_re    = cmd.accept || cmd.miss_eval;
  assign ctr_raddr = cmd.accept ? sig_in : vsig_now;

  shipdr_ram #(.WIDTH(2), .DEPTH(SIG_CNT)) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .re    (ctr_re),
    .raddr (ctr_raddr),
    .rdata (ctr_q)
  );

  assign ctr_inc = (ctr_q == shipdr_pkg::CTR_MAX) ? ctr_q : ctr_q + 2'd1;
  assign ctr_dec = (ctr_q == 2'd0) ? ctr_q : ctr_q - 2'd1;

  // ---------------- aging and victim selection ----------------
  logic [1:0]          rr   [WAYS];
  logic [1:0]          aged [WAYS];
  logic [SIG_BITS-1:0] sg   [WAYS];
  logic                hi_any, lo_any;
  logic [1:0]          age_add;
  logic [WAY_W-1:0]    victim_now;
  logic [RR_ROW_W-1:0] aged_row;

  always_comb begin
    hi_any = 1'b0;
    lo_any = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      rr[w] = rr_row_q[w*2 +: 2];
      sg[w] = sg_row_q[w*SIG_BITS +: SIG_BITS];
      hi_any = hi_any | rr[w][1];
    end
    for (int w = 0; w < WAYS; w++) begin
      if (rr[w][1] == hi_any) lo_any = lo_any | rr[w][0];
    end
    age_add    = shipdr_pkg::RRPV_DISTANT - {hi_any, lo_any};
    victim_now = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      aged[w] = rr[w] + age_add;
      aged_row[w*2 +: 2] = aged[w];
      if (aged[w] == shipdr_pkg::RRPV_DISTANT) victim_now = WAY_W'(w);
    end
    vsig_now = sg[victim_now];
  end

  logic [RR_ROW_W-1:0] aged_r;
  logic [WAY_W-1:0]    victim_r;
  logic [1:0]          ctr_sig_r;

  always_ff @(posedge clk) begin
    if (cmd.miss_eval) begin
      aged_r    <= aged_row;
      victim_r  <= victim_now;
      vsig_r    <= vsig_now;
      ctr_sig_r <= ctr_q;
    end
  end

  // ---------------- policy ----------------
  logic [shipdr_pkg::PSEL_W-1:0] psel_r;
  logic [shipdr_pkg::BIM_W-1:0]  bim_r;
  logic                          srrip_ldr, brrip_ldr, srrip_mode, use_brrip;
  logic [1:0]                    ctr_now, ins_rrpv;

  assign srrip_ldr  = (32'(set_r) < LEADER_SETS);
  assign brrip_ldr  = !srrip_ldr && (32'(set_r) < 2 * LEADER_SETS);
  assign srrip_mode = srrip_ldr || (!brrip_ldr && (psel_r >= shipdr_pkg::PSEL_MID));
  // victim counter decrement may land on the access signature itself
  assign ctr_now    = (vsig_r == sig_r) ? ctr_dec : ctr_sig_r;
  assign use_brrip  = (ctr_now < shipdr_pkg::CTR_STRONG) && !srrip_mode;

  always_comb begin
    if (ctr_now >= shipdr_pkg::CTR_STRONG) ins_rrpv = shipdr_pkg::RRPV_NEAR;
    else if (srrip_mode) ins_rrpv = shipdr_pkg::RRPV_LONG;
    else if (bim_r == '0) ins_rrpv = shipdr_pkg::RRPV_LONG;
    else ins_rrpv = shipdr_pkg::RRPV_DISTANT;
  end

  always_comb begin
    rr_hit_row  = rr_row_q;
    rr_miss_row = aged_r;
    sg_miss_row = sg_row_q;
    rr_hit_row[way_r*2 +: 2]             = shipdr_pkg::RRPV_NEAR;
    rr_miss_row[victim_r*2 +: 2]         = ins_rrpv;
    sg_miss_row[victim_r*SIG_BITS +: SIG_BITS] = sig_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psel_r <= shipdr_pkg::PSEL_MID;
      bim_r  <= '0;
    end else begin
      if (cmd.hit_wr) begin
        if (srrip_ldr) begin
          if (psel_r != shipdr_pkg::PSEL_MAX) psel_r <= psel_r + 10'd1;
        end else if (brrip_ldr) begin
          if (psel_r != '0) psel_r <= psel_r - 10'd1;
        end
      end
      if (cmd.miss_wr && use_brrip) bim_r <= bim_r + 5'd1;
    end
  end

  // ---------------- output register ----------------
  logic                               out_valid_r;
  logic [shipdr_pkg::WAY_OUT_W-1:0]   chosen_r;
  logic                               victim_flag_r;
  logic [31:0]                        way_ext, vic_ext;

  assign way_ext = 32'(way_r);
  assign vic_ext = 32'(victim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.hit_wr || cmd.miss_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_wr) begin
      chosen_r      <= way_ext[shipdr_pkg::WAY_OUT_W-1:0];
      victim_flag_r <= 1'b0;
    end else if (cmd.miss_wr) begin
      chosen_r      <= vic_ext[shipdr_pkg::WAY_OUT_W-1:0];
      victim_flag_r <= 1'b1;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign chosen_way_o = chosen_r;
  assign is_victim_o  = victim_flag_r;

  assign sts.clr_last = (clr_cnt_r == CLR_W'(CLR_LEN - 1));
  assign sts.hit      = hit_r;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

`default_nettype wire

[rtl/ship_drrip_cache_replacement_top.sv]
// Top level of the SHiP-lite / DRRIP replacement engine.
// Depends on shipdr_pkg, shipdr_ctrl, shipdr_dpath (and shipdr_ram below it).
//
//  channel | ports                         | payload
//  --------+-------------------------------+-------------------------------------------
//  in      | in_tvalid/in_tready/in_tdata  | set_index, hit_way, pc; in_tuser = hit
//  out     | out_tvalid/out_tready/out_tdata | chosen_way; out_tuser = is_victim
//
// A hit is accepted, then its row is updated; a miss is accepted, then the set is aged
// and the victim picked while its signature counter is read, then the victim is filled:
// the one read port of the counter RAM is needed once for the access signature and once
// for the victim's. After reset a clearing pass over every metadata row and signature
// counter fills the metadata RAMs; in_tready stays low until it ends. A result waits in
// the output register while the next item is taken; a second finished result stalls.
`default_nettype none

module ship_drrip_cache_replacement_top #(
  parameter int SETS           = shipdr_pkg::SETS_DEF,
  parameter int WAYS           = shipdr_pkg::WAYS_DEF,
  parameter int LEADER_SETS    = shipdr_pkg::LEADER_SETS_DEF,
  parameter int SIGNATURE_BITS = shipdr_pkg::SIG_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata, low bit up: set_index[10:0], hit_way[14:11], pc[32:15], zero pad
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,
  // in_tuser: hit
  input  wire logic        in_tuser,
  // out_tdata, low bit up: chosen_way[3:0], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,
  // out_tuser: is_victim
  output logic             out_tuser
);

  shipdr_pkg::cmd_t    cmd;
  shipdr_pkg::status_t sts;
  logic [shipdr_pkg::WAY_OUT_W-1:0] chosen_way;

  // Sequencer: owns the handshake on the input side.
  shipdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Metadata storage, policy state and output register.
  shipdr_dpath #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .LEADER_SETS (LEADER_SETS),
    .SIG_BITS    (SIGNATURE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .set_index_i  (in_tdata[10:0]),
    .hit_way_i    (in_tdata[14:11]),
    .pc_i         (in_tdata[32:15]),
    .hit_i        (in_tuser),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .chosen_way_o (chosen_way),
    .is_victim_o  (out_tuser)
  );

  assign out_tdata = {4'b0000, chosen_way};

endmodule

`default_nettype wire
